// ----- rtl/byte_ring_fifo_defines.svh -----
// Assertion macros shared by the byte ring FIFO RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef BYTE_RING_FIFO_DEFINES_SVH
`define BYTE_RING_FIFO_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring FIFO check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring FIFO check failed");
`else
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BRF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/brf_pkg.sv -----
// Shared constants for the byte ring FIFO: operation codes, field widths
// and register map. Depends on nothing.
package brf_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int LEVEL_W = 7;
    localparam int HPOS_W  = 6;
    localparam int CAP_W   = 7;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_SKIP  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OP_W-1:0] OP_BURST = 3'd5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Word index of each register; byte address is four times the index.
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

endpackage

// ----- rtl/byte_ring_fifo.sv -----
// Byte ring FIFO top level: command port, APB register port and the ring
// control. Depends on brf_pkg, brf_ram and byte_ring_fifo_defines.svh.
//
//   channel    | handshake            | payload
//   -----------+----------------------+-------------------------------------
//   command    | start, busy          | operation, data_in, count
//   result     | done (one cycle)     | data_out, accepted, level,
//              |                      | head_position, last
//   registers  | psel, penable,       | paddr, pwdata, prdata
//              | pwrite, pready       |
//
// A command word is taken at a rising edge with start high and busy low; its
// first result word is on done for one cycle, after the stage register (with the
// RAM read register) and the result register. Push, pop, peek, skip, clear and
// unused codes leave busy low, so they run back to back; a read burst holds busy
// high until its last byte is read from the RAM. After reset a clearing pass
// zeroes the store with busy high. The receiver cannot stall.
`include "byte_ring_fifo_defines.svh"

module byte_ring_fifo #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [brf_pkg::OP_W-1:0]        operation,
    input  logic [brf_pkg::BYTE_W-1:0]      data_in,
    input  logic [brf_pkg::COUNT_W-1:0]     count,
    // Result channel
    output logic                            done,
    output logic [brf_pkg::BYTE_W-1:0]      data_out,
    output logic                            accepted,
    output logic [brf_pkg::LEVEL_W-1:0]     level,
    output logic [brf_pkg::HPOS_W-1:0]      head_position,
    output logic                            last,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [brf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [brf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    // Head indexes a slot; the fill count must also hold DEPTH itself.
    localparam int HEAD_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    // Common width for comparing the 7-bit register and count fields
    // against DEPTH-sized quantities.
    localparam int CMP_W  = (FILL_W > brf_pkg::CAP_W) ? FILL_W : brf_pkg::CAP_W;
    localparam int HX_W   = (HEAD_W > brf_pkg::HPOS_W) ? HEAD_W : brf_pkg::HPOS_W;

    // Result word between the RAM access and the output register.
    typedef struct packed {
        logic              valid;
        logic              use_ram;
        logic              accepted;
        logic              last;
        logic [FILL_W-1:0] level;
        logic [HEAD_W-1:0] head;
    } stage_t;

    // Advance a slot index with one compare-subtract against the capacity.
    function automatic logic [HEAD_W-1:0] wrap_add(
        input logic [HEAD_W-1:0] a,
        input logic [FILL_W-1:0] b,
        input logic [FILL_W-1:0] cap
    );
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] c;
        begin
            c = SUM_W'(cap);
            s = SUM_W'(a) + SUM_W'(b);
            if (s >= c)
            begin
                s = s - c;
            end
            if (s >= c)
            begin
                s = '0;
            end
            return s[HEAD_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [brf_pkg::CAP_W-1:0] capacity_reg;
    logic [brf_pkg::CAP_W-1:0] capacity_next;
    logic                      cfg_write;
    logic                      cap_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cap_write = cfg_write && (paddr[2] == brf_pkg::REG_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cap_write)
        begin
            capacity_next = pwdata[brf_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == brf_pkg::REG_CAPACITY)
        begin
            prdata = brf_pkg::APB_DATA_W'(capacity_reg);
        end
    end

    // Zero acts as one and anything above DEPTH acts as DEPTH.
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_lim;
    logic [FILL_W-1:0] cap_eff;

    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_lim = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(DEPTH))
        begin
            cap_lim = CMP_W'(DEPTH);
        end
        else
        begin
            cap_lim = cap_ext;
        end
        cap_eff = cap_lim[FILL_W-1:0];
    end

    // ------------------------------------------------------------------
    // Ring state, clearing pass and burst sequencer
    // ------------------------------------------------------------------
    logic [HEAD_W-1:0] head_reg,     head_next;
    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic              burst_reg,    burst_next;
    logic [FILL_W-1:0] remain_reg,   remain_next;
    logic              clr_reg,      clr_next;
    logic [HEAD_W-1:0] clr_addr_reg, clr_addr_next;
    stage_t            stage_reg,    stage_next;

    logic              ram_en;
    logic              ram_we;
    logic [HEAD_W-1:0] ram_addr;
    logic [brf_pkg::BYTE_W-1:0] ram_wdata;
    logic [brf_pkg::BYTE_W-1:0] ram_rdata;

    logic              take;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  count_ext;
    logic [FILL_W-1:0] n_avail;

    assign busy  = clr_reg || burst_reg;
    assign take  = start && !busy;
    assign full  = (fill_reg >= cap_eff);
    assign empty = (fill_reg == '0);

    // Bytes a skip or burst can act on: min(count, fill).
    always_comb
    begin
        count_ext = CMP_W'(count);
        if (count_ext < CMP_W'(fill_reg))
        begin
            n_avail = count_ext[FILL_W-1:0];
        end
        else
        begin
            n_avail = fill_reg;
        end
    end

    // Clearing pass: one slot per cycle after reset.
    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + HEAD_W'(1);
            if (clr_addr_reg == HEAD_W'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        burst_next  = burst_reg;
        remain_next = remain_reg;
        stage_next  = '0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = head_reg;
        ram_wdata   = data_in;

        if (clr_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (burst_reg)
        begin
            // Remaining bytes of a read burst, one RAM read per cycle.
            ram_en               = 1'b1;
            head_next            = wrap_add(head_reg, FILL_W'(1), cap_eff);
            fill_next            = fill_reg - FILL_W'(1);
            remain_next          = remain_reg - FILL_W'(1);
            burst_next           = (remain_reg != FILL_W'(1));
            stage_next.valid     = 1'b1;
            stage_next.use_ram   = 1'b1;
            stage_next.accepted  = 1'b1;
            stage_next.last      = (remain_reg == FILL_W'(1));
        end
        else if (take)
        begin
            stage_next.valid = 1'b1;
            stage_next.last  = 1'b1;
            case (operation)
                brf_pkg::OP_PUSH:
                begin
                    if (!full)
                    begin
                        ram_en              = 1'b1;
                        ram_we              = 1'b1;
                        ram_addr            = wrap_add(head_reg, fill_reg, cap_eff);
                        fill_next           = fill_reg + FILL_W'(1);
                        stage_next.accepted = 1'b1;
                    end
                end
                brf_pkg::OP_POP:
                begin
                    if (!empty)
                    begin
                        ram_en              = 1'b1;
                        head_next           = wrap_add(head_reg, FILL_W'(1), cap_eff);
                        fill_next           = fill_reg - FILL_W'(1);
                        stage_next.use_ram  = 1'b1;
                        stage_next.accepted = 1'b1;
                    end
                end
                brf_pkg::OP_PEEK:
                begin
                    // An empty ring still shows the stale byte at the head.
                    ram_en              = 1'b1;
                    stage_next.use_ram  = 1'b1;
                    stage_next.accepted = 1'b1;
                end
                brf_pkg::OP_SKIP:
                begin
                    head_next           = wrap_add(head_reg, n_avail, cap_eff);
                    fill_next           = fill_reg - n_avail;
                    stage_next.accepted = 1'b1;
                end
                brf_pkg::OP_CLEAR:
                begin
                    head_next           = '0;
                    fill_next           = '0;
                    stage_next.accepted = 1'b1;
                end
                brf_pkg::OP_BURST:
                begin
                    if (n_avail != '0)
                    begin
                        ram_en              = 1'b1;
                        head_next           = wrap_add(head_reg, FILL_W'(1), cap_eff);
                        fill_next           = fill_reg - FILL_W'(1);
                        remain_next         = n_avail - FILL_W'(1);
                        burst_next          = (n_avail != FILL_W'(1));
                        stage_next.use_ram  = 1'b1;
                        stage_next.accepted = 1'b1;
                        stage_next.last     = (n_avail == FILL_W'(1));
                    end
                end
                default:
                begin
                    stage_next.accepted = 1'b0;
                end
            endcase
        end

        // Every result reports the state it leaves behind.
        stage_next.level = fill_next;
        stage_next.head  = head_next;

        // A capacity write restarts the ring; the user must write it only while idle (not enforced here).
        if (cap_write)
        begin
            head_next = '0;
            fill_next = '0;
        end
    end

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                        done_reg;
    logic [brf_pkg::BYTE_W-1:0]  data_out_reg,      data_out_next;
    logic                        accepted_reg;
    logic [brf_pkg::LEVEL_W-1:0] level_reg,         level_next;
    logic [brf_pkg::HPOS_W-1:0]  head_position_reg, head_position_next;
    logic                        last_reg;
    logic [CMP_W-1:0]            level_ext;
    logic [HX_W-1:0]             head_ext;

    always_comb
    begin
        level_ext          = CMP_W'(stage_reg.level);
        head_ext           = HX_W'(stage_reg.head);
        level_next         = level_ext[brf_pkg::LEVEL_W-1:0];
        head_position_next = head_ext[brf_pkg::HPOS_W-1:0];
        data_out_next      = stage_reg.use_ram ? ram_rdata : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= brf_pkg::CAPACITY_RESET;
            head_reg     <= '0;
            fill_reg     <= '0;
            burst_reg    <= 1'b0;
            remain_reg   <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            stage_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            burst_reg    <= burst_next;
            remain_reg   <= remain_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            stage_reg    <= stage_next;
            done_reg     <= stage_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg      <= data_out_next;
        accepted_reg      <= stage_reg.accepted;
        level_reg         <= level_next;
        head_position_reg <= head_position_next;
        last_reg          <= stage_reg.last;
    end

    assign done          = done_reg;
    assign data_out      = data_out_reg;
    assign accepted      = accepted_reg;
    assign level         = level_reg;
    assign head_position = head_position_reg;
    assign last          = last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BRF_ASSERT_IMP(a_fill_in_cap, clk, rst_n, 1'b1, fill_reg <= cap_eff)
    `BRF_ASSERT_IMP(a_head_in_cap, clk, rst_n, 1'b1, FILL_W'(head_reg) < cap_eff)
    `BRF_ASSERT_NXT(a_burst_continues, clk, rst_n, done_reg && !last_reg, done_reg)
    `BRF_ASSERT_IMP(a_burst_no_write, clk, rst_n, burst_reg, !ram_we)
    `BRF_ASSERT_IMP(a_burst_has_bytes, clk, rst_n, burst_reg,
                    (remain_reg != '0) && (fill_reg >= remain_reg))

endmodule

// ----- rtl/brf_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sim/byte_ring_fifo_tb.sv -----
// Self-checking testbench for the byte ring FIFO: directed and random command words,
// capacity writes over the APB port, and a scoreboard of predicted result words.
// Depends on brf_pkg and the byte_ring_fifo RTL.
module byte_ring_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes the block does not define. They must be refused with one
    // result word and no change of state.
    localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [brf_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int RING_SLOTS  = brf_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [brf_pkg::OP_W-1:0]    op;
        logic [brf_pkg::BYTE_W-1:0]  data;
        logic [brf_pkg::COUNT_W-1:0] cnt;
    } command_t;

    typedef struct packed {
        logic [brf_pkg::BYTE_W-1:0]  data_out;
        logic                        accepted;
        logic [brf_pkg::LEVEL_W-1:0] level;
        logic [brf_pkg::HPOS_W-1:0]  head_position;
        logic                        last;
    } result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [brf_pkg::OP_W-1:0]           operation = brf_pkg::OP_PUSH;
    logic [brf_pkg::BYTE_W-1:0]         data_in = '0;
    logic [brf_pkg::COUNT_W-1:0]        count = '0;
    logic                               done;
    logic [brf_pkg::BYTE_W-1:0]         data_out;
    logic                               accepted;
    logic [brf_pkg::LEVEL_W-1:0]        level;
    logic [brf_pkg::HPOS_W-1:0]         head_position;
    logic                               last;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [brf_pkg::APB_ADDR_W-1:0]     paddr = '0;
    logic [brf_pkg::APB_DATA_W-1:0]     pwdata = '0;
    logic [brf_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    // Command words waiting to be driven, and result words still owed by the block.
    command_t cmd_q[$];
    result_t  due_results[$];

    // Percentage of cycles in which the command side stays idle in this phase.
    int sender_idle_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // Private copy of the ring: store, head, fill and the capacity register.
    logic [brf_pkg::BYTE_W-1:0] ring_store[RING_SLOTS];
    int                         ring_head;
    int                         ring_fill;
    logic [brf_pkg::CAP_W-1:0]  ring_cap;

    byte_ring_fifo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .data_in       (data_in),
        .count         (count),
        .done          (done),
        .data_out      (data_out),
        .accepted      (accepted),
        .level         (level),
        .head_position (head_position),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    // Capacity in force: zero behaves as one slot, anything above the store size
    // behaves as the full store.
    function automatic int ring_span();
        if (ring_cap == '0)
            return 1;
        if (int'(ring_cap) > RING_SLOTS)
            return RING_SLOTS;
        return int'(ring_cap);
    endfunction

    // Head advance by a single compare-subtract against the capacity. A sum that
    // is still out of range after one subtraction lands on slot zero.
    function automatic int ring_advance(input int pos, input int step, input int span);
        int sum;
        sum = pos + step;
        if (sum >= span)
            sum -= span;
        if (sum >= span)
            sum = 0;
        return sum;
    endfunction

    // Records one owed result word, with level and head taken after the update.
    function automatic void owe_result(input logic [brf_pkg::BYTE_W-1:0] value,
                                       input logic ok, input logic final_word);
        result_t r;
        r.data_out      = value;
        r.accepted      = ok;
        r.level         = brf_pkg::LEVEL_W'(ring_fill);
        r.head_position = brf_pkg::HPOS_W'(ring_head);
        r.last          = final_word;
        due_results.push_back(r);
    endfunction

    // Applies one accepted command word to the private ring and queues every
    // result word it must produce.
    function automatic void ring_apply(input command_t c);
        int span;
        int n;
        int slot;
        span = ring_span();
        case (c.op)
            brf_pkg::OP_PUSH:
            begin
                if (ring_fill >= span)
                begin
                    owe_result('0, 1'b0, 1'b1);
                end
                else
                begin
                    slot = ring_advance(ring_head, ring_fill, span);
                    ring_store[slot] = c.data;
                    ring_fill++;
                    owe_result('0, 1'b1, 1'b1);
                end
            end
            brf_pkg::OP_POP:
            begin
                if (ring_fill == 0)
                begin
                    owe_result('0, 1'b0, 1'b1);
                end
                else
                begin
                    slot = ring_head;
                    ring_head = ring_advance(ring_head, 1, span);
                    ring_fill--;
                    owe_result(ring_store[slot], 1'b1, 1'b1);
                end
            end
            brf_pkg::OP_PEEK:
            begin
                // An empty ring still shows whatever byte sits in the head slot.
                owe_result(ring_store[ring_head], 1'b1, 1'b1);
            end
            brf_pkg::OP_SKIP:
            begin
                n = (int'(c.cnt) < ring_fill) ? int'(c.cnt) : ring_fill;
                ring_head = ring_advance(ring_head, n, span);
                ring_fill -= n;
                owe_result('0, 1'b1, 1'b1);
            end
            brf_pkg::OP_CLEAR:
            begin
                ring_head = 0;
                ring_fill = 0;
                owe_result('0, 1'b1, 1'b1);
            end
            brf_pkg::OP_BURST:
            begin
                n = (int'(c.cnt) < ring_fill) ? int'(c.cnt) : ring_fill;
                // A burst that moves no byte gives a single refused word.
                if (n == 0)
                    owe_result('0, 1'b0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    slot = ring_head;
                    ring_head = ring_advance(ring_head, 1, span);
                    ring_fill--;
                    owe_result(ring_store[slot], 1'b1, (i == n - 1));
                end
            end
            default:
            begin
                owe_result('0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Command driver. A word is taken at an edge with start high and busy low;
    // the prediction is made at that same edge. While busy is high the word on
    // the port is held. Otherwise the next word is put up, or the port idles.
    always @(posedge clk)
    begin
        command_t c;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                c.op   = operation;
                c.data = data_in;
                c.cnt  = count;
                ring_apply(c);
            end
            if (!start || !busy)
            begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    c = cmd_q.pop_front();
                    start     <= 1'b1;
                    operation <= c.op;
                    data_in   <= c.data;
                    count     <= c.cnt;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [brf_pkg::BYTE_W-1:0] want,
                               input logic [brf_pkg::BYTE_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Result monitor. The receiver cannot stall, so every cycle with done high
    // carries a word, which is matched against the oldest owed word.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                fail_count++;
                $error("result word arrived with nothing expected");
            end
            else
            begin
                want = due_results.pop_front();
                check_field("data_out", want.data_out, data_out);
                check_field("accepted", brf_pkg::BYTE_W'(want.accepted),
                            brf_pkg::BYTE_W'(accepted));
                check_field("level", brf_pkg::BYTE_W'(want.level), brf_pkg::BYTE_W'(level));
                check_field("head_position", brf_pkg::BYTE_W'(want.head_position),
                            brf_pkg::BYTE_W'(head_position));
                check_field("last", brf_pkg::BYTE_W'(want.last), brf_pkg::BYTE_W'(last));
            end
        end
    end

    // Watchdog: a hung handshake or a word the block never produces ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("byte_ring_fifo regression: fail");
            $finish;
        end
    end

    // Writes the capacity register with a setup and an access cycle. The block
    // clears head and fill on this write, and the private ring follows.
    task automatic write_capacity(input logic [brf_pkg::CAP_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {brf_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= brf_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_cap  = value;
        ring_head = 0;
        ring_fill = 0;
        @(negedge clk);
    endtask

    task automatic queue_command(input logic [brf_pkg::OP_W-1:0] op,
                                 input logic [brf_pkg::BYTE_W-1:0] data,
                                 input logic [brf_pkg::COUNT_W-1:0] cnt);
        command_t c;
        c.op   = op;
        c.data = data;
        c.cnt  = cnt;
        cmd_q.push_back(c);
    endtask

    // Returns once every queued word has been taken and every owed word has come.
    // Sampling on the falling edge keeps clear of the updates made at the rising one.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || start || due_results.size() != 0);
    endtask

    function automatic logic [brf_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return brf_pkg::OP_PUSH;
        if (r < 48)
            return brf_pkg::OP_POP;
        if (r < 56)
            return brf_pkg::OP_PEEK;
        if (r < 66)
            return brf_pkg::OP_SKIP;
        if (r < 70)
            return brf_pkg::OP_CLEAR;
        if (r < 94)
            return brf_pkg::OP_BURST;
        return ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    endfunction

    // Counts mostly stay near the capacity so that skips and bursts hit the
    // interesting boundaries, with the full seven-bit range now and then.
    function automatic logic [brf_pkg::COUNT_W-1:0] pick_count();
        if ($urandom_range(3) != 0)
            return brf_pkg::COUNT_W'($urandom_range(0, ring_span() + 1));
        return brf_pkg::COUNT_W'($urandom_range(0, 127));
    endfunction

    // Random words are a mix of single operations and runs of pushes long enough
    // to fill the ring, so that refusal on a full ring and wrapping of the head
    // are reached often.
    task automatic queue_random(input int n_words);
        int made;
        int run;
        made = 0;
        while (made < n_words)
        begin
            if ($urandom_range(3) == 0)
            begin
                run = $urandom_range(1, ring_span() + 1);
                if (run > n_words - made)
                    run = n_words - made;
                repeat (run)
                    queue_command(brf_pkg::OP_PUSH, brf_pkg::BYTE_W'($urandom),
                                  brf_pkg::COUNT_W'($urandom));
                made += run;
            end
            else
            begin
                queue_command(pick_op(), brf_pkg::BYTE_W'($urandom), pick_count());
                made++;
            end
        end
    endtask

    task automatic run_random_phase(input logic [brf_pkg::CAP_W-1:0] cap_value,
                                    input int idle_pct, input int n_words);
        write_capacity(cap_value);
        sender_idle_pct = idle_pct;
        queue_random(n_words);
        wait_idle();
    endtask

    initial
    begin
        foreach (ring_store[i])
            ring_store[i] = '0;
        ring_head = 0;
        ring_fill = 0;
        ring_cap  = brf_pkg::CAPACITY_RESET;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset capacity. The block is still running its
        // clearing pass here, so the first word waits on busy.
        sender_idle_pct = 0;
        queue_command(brf_pkg::OP_POP, 8'h00, 7'd0);     // pop on an empty ring is refused
        queue_command(brf_pkg::OP_PEEK, 8'h00, 7'd0);    // empty peek shows the stale byte
        queue_command(brf_pkg::OP_BURST, 8'h00, 7'd0);   // burst of zero bytes is refused
        queue_command(brf_pkg::OP_BURST, 8'h00, 7'd5);   // burst on an empty ring is refused
        queue_command(brf_pkg::OP_SKIP, 8'hFF, 7'd127);  // skip on an empty ring drops nothing
        queue_command(OP_UNUSED_6, 8'hFF, 7'd127);       // undefined code
        queue_command(brf_pkg::OP_PUSH, 8'h00, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'hFF, 7'd127);
        queue_command(brf_pkg::OP_PUSH, 8'hA5, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h3C, 7'd0);
        queue_command(brf_pkg::OP_PEEK, 8'h00, 7'd0);
        queue_command(brf_pkg::OP_BURST, 8'h00, 7'd0);   // data held, but zero asked for
        queue_command(brf_pkg::OP_SKIP, 8'h00, 7'd1);
        queue_command(brf_pkg::OP_POP, 8'h00, 7'd0);
        queue_command(brf_pkg::OP_BURST, 8'h00, 7'd127); // count above the level is cut to it
        queue_command(brf_pkg::OP_PUSH, 8'h81, 7'd0);
        queue_command(brf_pkg::OP_CLEAR, 8'h00, 7'd0);
        queue_command(brf_pkg::OP_PEEK, 8'h00, 7'd0);    // stale byte at slot zero after clear
        wait_idle();

        // Capacity zero behaves as a single slot: the second push is refused and
        // the head wraps onto itself.
        write_capacity(7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h5A, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h11, 7'd0);
        queue_command(brf_pkg::OP_POP, 8'h00, 7'd0);
        queue_command(brf_pkg::OP_POP, 8'h00, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h22, 7'd0);
        queue_command(brf_pkg::OP_BURST, 8'h00, 7'd64);
        wait_idle();

        // A three-slot ring: fill it, overflow it, then burst across the wrap.
        write_capacity(7'd3);
        queue_command(brf_pkg::OP_PUSH, 8'h01, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h02, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h03, 7'd0);
        queue_command(brf_pkg::OP_PUSH, 8'h04, 7'd0);
        queue_command(brf_pkg::OP_SKIP, 8'h00, 7'd2);
        queue_command(brf_pkg::OP_PUSH, 8'h05, 7'd0);
        queue_command(brf_pkg::OP_BURST, 8'h00, 7'd64);
        wait_idle();

        // Random phases over the capacity extremes and the idle patterns. The
        // receiver never stalls, so only the command side is throttled.
        run_random_phase(7'd64, 0, 80);
        run_random_phase(7'd1, 65, 45);
        run_random_phase(7'd127, 33, 70);
        run_random_phase(brf_pkg::CAP_W'($urandom_range(2, 63)), 0, 60);
        run_random_phase(7'd0, 65, 40);
        run_random_phase(brf_pkg::CAP_W'($urandom_range(2, 63)), 33, 40);

        // Every word is in; wait for anything the block still sends.
        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("byte_ring_fifo regression: pass");
        else
            $display("byte_ring_fifo regression: fail");
        $finish;
    end

endmodule
